@@ src/p2slm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2slm_pkg
// Shared constants, field widths and inter-module control types of the
// two-step PTP latency monitor.
// ----------------------------------------------------------------------------
package p2slm_pkg;

  // Ring of absolute deltas used for the running average
  localparam int WINDOW_SLOTS = 20;
  localparam int SLOT_W       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  // Slot index = sequence mod WINDOW_SLOTS through a scaled reciprocal
  localparam int          RECIP_SHIFT = 24;
  localparam int          RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned SLOT_RECIP  =
    ((32'd1 << RECIP_SHIFT) + WINDOW_SLOTS - 1) / WINDOW_SLOTS;

  // Radix-16 divider by WINDOW_SLOTS
  localparam int REM_W     = $clog2(WINDOW_SLOTS + 1);
  localparam int DIV_STEPS = 16;

  localparam logic [15:0] PTP_ETHERTYPE = 16'h88F7;
  localparam logic [3:0]  MSG_SYNC      = 4'h0;
  localparam logic [3:0]  MSG_FOLLOW    = 4'h8;
  localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;

  localparam int IN_DATA_W  = 176;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 224;
  localparam int OUT_USER_W = 1;

  typedef struct packed {
    logic        start;
    logic [47:0] seconds;
    logic [29:0] nanoseconds;
  } conv_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] ns;
  } conv_rsp_t;

  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       mag;
  } win_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] sum;
  } win_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

@@ src/p2slm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2slm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module p2slm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 20,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/p2slm_ns_conv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2slm_ns_conv
// Timestamp to nanoseconds: seconds * 1e9 + nanoseconds, modulo 2^64.
// Two split partial products, then one merge add, each registered.
// ----------------------------------------------------------------------------
module p2slm_ns_conv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  p2slm_pkg::conv_req_t req_i,
  output p2slm_pkg::conv_rsp_t rsp_o
);

  logic [53:0] prod_lo_q;
  logic [53:0] prod_hi_q;
  logic [29:0] nsec_q;
  logic        stage_q;
  logic [63:0] ns_q;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= req_i.start;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_lo_q <= 54'(req_i.seconds[23:0]) * 54'(p2slm_pkg::NS_PER_SEC);
      prod_hi_q <= 54'(req_i.seconds[47:24]) * 54'(p2slm_pkg::NS_PER_SEC);
      nsec_q    <= req_i.nanoseconds;
    end
    // upper partial product weighs 2^24; bits above 2^64 drop out
    if (stage_q) begin
      ns_q <= {10'd0, prod_lo_q} + {prod_hi_q[39:0], 24'd0} + {34'd0, nsec_q};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ns   = ns_q;

endmodule

@@ src/p2slm_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2slm_window
// Ring of absolute deltas held in a RAM. A request writes one slot, then
// sweeps all slots one read per cycle and returns their sum modulo 2^64.
// Slots never written read as zero through per-slot valid bits.
// ----------------------------------------------------------------------------
module p2slm_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  p2slm_pkg::win_req_t req_i,
  output p2slm_pkg::win_rsp_t rsp_o
);

  localparam int                       SW   = p2slm_pkg::SLOT_W;
  localparam logic [SW-1:0]            LAST = SW'(p2slm_pkg::WINDOW_SLOTS - 1);

  logic [p2slm_pkg::WINDOW_SLOTS-1:0] valid_q;
  logic                               issue_q;
  logic [SW-1:0]                      rd_idx_q;
  logic                               rvalid_q;
  logic                               rlast_q;
  logic [SW-1:0]                      raddr_q;
  logic [63:0]                        sum_q;
  logic                               done_q;
  logic [63:0]                        rdata;

  p2slm_ram #(
    .WIDTH(64),
    .DEPTH(p2slm_pkg::WINDOW_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.start),
    .waddr_i(req_i.slot),
    .wdata_i(req_i.mag),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      issue_q  <= 1'b0;
      rd_idx_q <= '0;
      rvalid_q <= 1'b0;
      rlast_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (req_i.start) begin
        valid_q[req_i.slot] <= 1'b1;
      end
      // start the sweep in the cycle after the write so slot reads see it
      if (req_i.start) begin
        issue_q  <= 1'b1;
        rd_idx_q <= '0;
      end else if (issue_q) begin
        if (rd_idx_q == LAST) begin
          issue_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + SW'(1);
        end
      end
      rvalid_q <= issue_q;
      rlast_q  <= issue_q && (rd_idx_q == LAST);
      done_q   <= rvalid_q && rlast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= rd_idx_q;
    if (req_i.start) begin
      sum_q <= '0;
    end else if (rvalid_q && valid_q[raddr_q]) begin
      sum_q <= sum_q + rdata;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sum  = sum_q;

endmodule

@@ src/p2slm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2slm_div
// Unsigned 64-bit division by the window size, one hex digit per cycle.
// Each step compares the partial remainder against the fifteen digit
// multiples of the divisor in parallel; quotient is ready after 16 steps.
// ----------------------------------------------------------------------------
module p2slm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  p2slm_pkg::div_req_t req_i,
  output p2slm_pkg::div_rsp_t rsp_o
);

  localparam int RW    = p2slm_pkg::REM_W;
  localparam int VW    = RW + 4;
  localparam int CNT_W = $clog2(p2slm_pkg::DIV_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    rem_q;
  logic [63:0]      dvd_q;
  logic [63:0]      quo_q;

  logic [VW-1:0]    step_val;
  logic [3:0]       digit;
  logic [RW-1:0]    rem_nx;

  always_comb begin
    step_val = {rem_q, dvd_q[63:60]};
    digit    = 4'd0;
    rem_nx   = step_val[RW-1:0];
    for (int k = 1; k < 16; k++) begin
      if (step_val >= VW'(k * p2slm_pkg::WINDOW_SLOTS)) begin
        digit  = 4'(k);
        rem_nx = RW'(step_val - VW'(k * p2slm_pkg::WINDOW_SLOTS));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(p2slm_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[59:0], 4'd0};
      rem_q <= rem_nx;
      quo_q <= {quo_q[59:0], digit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ src/ptp_two_step_latency_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_two_step_latency_monitor
// SYNC / follow-up delay monitor for two-step PTPv2 masters.
// ----------------------------------------------------------------------------
// Input stream: one item per received frame summary. Items with a foreign
// ethertype or a message type other than SYNC or follow-up are accepted
// and dropped. A SYNC updates the stored sequence, master and receive
// time and gives no result.
// A follow-up gives exactly one output item: the SYNC-minus-follow-up delta,
// the window average and the peak absolute delta, plus both sequence IDs in
// tdata and the master-match flag in tuser. Its processing runs through
// the 20-slot window sweep (one RAM read per cycle) and the 16-step divider.
// The block takes one item at a time; s_axis_tready_o is high while idle.
// The output register holds a finished item while the receiver stalls and
// the next input item is still accepted; a second result waits in the last
// stage until the register frees up.
// Reset clears all stored times, the master latch, the peak and the window
// valid bits at once; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module ptp_two_step_latency_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // eth_kind[15:0], src_clock[79:16], sequence_id[95:80],
  // stamp_seconds[143:96], stamp_nanoseconds[173:144], zero pad
  input  logic [p2slm_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // mode[3:0]
  input  logic [p2slm_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // round_trip_delta[63:0], average_delta[127:64], maximum_delta[191:128],
  // sync_sequence[207:192], follow_sequence[223:208]
  output logic [p2slm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // follow_accepted[0]
  output logic [p2slm_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CONV  = 8'b0000_0010,
    ST_APPLY = 8'b0000_0100,
    ST_DELTA = 8'b0000_1000,
    ST_MAG   = 8'b0001_0000,
    ST_WIN   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  localparam int SW = p2slm_pkg::SLOT_W;
  localparam int PW = 16 + p2slm_pkg::RECIP_W;

  state_e state_q, state_d;

  // input fields
  logic [15:0] in_ether;
  logic [3:0]  in_mode;
  logic [63:0] in_src;
  logic [15:0] in_seq;
  logic        in_fire;
  logic        in_relevant;

  logic        is_sync_q;
  logic [63:0] src_q;
  logic [15:0] seq_q;

  // monitor state
  logic [63:0] master_id_q;
  logic        master_latched_q;
  logic [15:0] last_sync_q;
  logic [15:0] last_follow_q;
  logic [63:0] sync_ns_q;
  logic [63:0] follow_ns_q;
  logic [63:0] peak_q;
  logic [63:0] delta_q;
  logic        accepted_q;
  logic        avg_neg_q;

  // slot index pipeline
  logic [PW-1:0] slot_prod_q;
  logic [21:0]   slot_qd_q;
  logic [15:0]   slot_rem;

  logic [63:0] mag;
  logic [63:0] avg;
  logic        out_load;

  logic                              out_valid_q;
  logic [p2slm_pkg::OUT_DATA_W-1:0]  out_data_q;
  logic                              out_acc_q;

  p2slm_pkg::conv_req_t conv_req;
  p2slm_pkg::conv_rsp_t conv_rsp;
  p2slm_pkg::win_req_t  win_req;
  p2slm_pkg::win_rsp_t  win_rsp;
  p2slm_pkg::div_req_t  div_req;
  p2slm_pkg::div_rsp_t  div_rsp;

  assign in_ether = s_axis_tdata_i[15:0];
  assign in_src   = s_axis_tdata_i[79:16];
  assign in_seq   = s_axis_tdata_i[95:80];
  assign in_mode  = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_relevant     = (in_ether == p2slm_pkg::PTP_ETHERTYPE) &&
                           ((in_mode == p2slm_pkg::MSG_SYNC) ||
                            (in_mode == p2slm_pkg::MSG_FOLLOW));

  assign conv_req.start       = in_fire && in_relevant;
  assign conv_req.seconds     = s_axis_tdata_i[143:96];
  assign conv_req.nanoseconds = s_axis_tdata_i[173:144];

  p2slm_ns_conv u_ns_conv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (conv_req),
    .rsp_o (conv_rsp)
  );

  // last SYNC sequence mod window size; product and quotient are registered
  always_ff @(posedge clk_i) begin
    slot_prod_q <= PW'(last_sync_q) * PW'(p2slm_pkg::SLOT_RECIP);
    slot_qd_q   <= 22'(slot_prod_q[p2slm_pkg::RECIP_SHIFT +: 16]) *
                   22'(p2slm_pkg::WINDOW_SLOTS);
  end
  assign slot_rem = last_sync_q - slot_qd_q[15:0];

  assign mag = delta_q[63] ? (64'd0 - delta_q) : delta_q;

  assign win_req.start = (state_q == ST_MAG);
  assign win_req.slot  = slot_rem[SW-1:0];
  assign win_req.mag   = mag;

  p2slm_window u_window (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (win_req),
    .rsp_o (win_rsp)
  );

  assign div_req.start    = (state_q == ST_WIN) && win_rsp.done;
  assign div_req.dividend = win_rsp.sum[63] ? (64'd0 - win_rsp.sum) : win_rsp.sum;

  p2slm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign avg      = avg_neg_q ? (64'd0 - div_rsp.quotient) : div_rsp.quotient;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire && in_relevant) state_d = ST_CONV;
      ST_CONV:  if (conv_rsp.done) state_d = ST_APPLY;
      ST_APPLY: state_d = is_sync_q ? ST_IDLE : ST_DELTA;
      ST_DELTA: state_d = ST_MAG;
      ST_MAG:   state_d = ST_WIN;
      ST_WIN:   if (win_rsp.done) state_d = ST_DIV;
      ST_DIV:   if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      master_id_q      <= '0;
      master_latched_q <= 1'b0;
      last_sync_q      <= '0;
      last_follow_q    <= '0;
      sync_ns_q        <= '0;
      follow_ns_q      <= '0;
      peak_q           <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_APPLY) begin
        if (is_sync_q) begin
          last_sync_q <= seq_q;
          if (!master_latched_q) begin
            master_id_q      <= src_q;
            master_latched_q <= 1'b1;
          end
          if (!master_latched_q || (src_q == master_id_q)) begin
            sync_ns_q <= conv_rsp.ns;
          end
        end else if (src_q == master_id_q) begin
          last_follow_q <= seq_q;
          follow_ns_q   <= conv_rsp.ns;
        end
      end
      // the most negative delta stays negative and never wins here
      if ((state_q == ST_MAG) && ($signed(mag) > $signed(peak_q))) begin
        peak_q <= mag;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_sync_q <= (in_mode == p2slm_pkg::MSG_SYNC);
      src_q     <= in_src;
      seq_q     <= in_seq;
    end
    if (state_q == ST_APPLY) begin
      accepted_q <= (src_q == master_id_q);
    end
    if (state_q == ST_DELTA) begin
      delta_q <= sync_ns_q - follow_ns_q;
    end
    if (div_req.start) begin
      avg_neg_q <= win_rsp.sum[63];
    end
    if (out_load) begin
      out_data_q <= {last_follow_q, last_sync_q, peak_q, avg, delta_q};
      out_acc_q  <= accepted_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_acc_q;

endmodule
